// ===== hw/rtl/slsf_pkg.sv =====
// ----------------------------------------------------------------------------
// slsf_pkg
// Shared types and codes of the LED strip frame serializer.
// ----------------------------------------------------------------------------
package slsf_pkg;

	localparam int LED_COUNT_DEF = 64;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 15;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_RGB    = 3'd1;
	localparam logic [2:0] OP_PACKED = 3'd2;
	localparam logic [2:0] OP_START  = 3'd3;
	localparam logic [2:0] OP_ANIM   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ANIM_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANIM_COLOR = 1'b1;

	localparam logic [1:0] ANIM_PIXEL = 2'd1;
	localparam logic [1:0] ANIM_LINE  = 2'd2;

	localparam logic [15:0] PIX_MARK = 16'h8000;

	typedef struct packed {
		logic        is_tick;
		logic        is_write;
		logic        is_start;
		logic        is_anim;
		logic [5:0]  index;
		logic [14:0] color;
	} item_t;

	typedef struct packed {
		logic data_bit;
		logic clock_pulse;
		logic busy;
	} result_t;

	typedef struct packed {
		logic init;
	} back_status_t;

endpackage

// ===== hw/rtl/led_strip_frame_serializer_core.sv =====
// ----------------------------------------------------------------------------
// led_strip_frame_serializer_core
// Pixel store and frame sequencer for an RGB555 clock/data LED strip.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result, in order. Items flow at one
// per cycle while both queues move; a tick that begins a new pixel's bits
// waits for the pixel store read first. An animation step that clears the
// store holds the back end while every store row is rewritten, one store row
// per cycle. After reset a clearing pass runs with full held high;
// configuration writes are always ready.
module led_strip_frame_serializer_core
	import slsf_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [2:0]            opcode,
	input  logic [5:0]            pixel_index,
	input  logic [4:0]            red,
	input  logic [4:0]            green,
	input  logic [4:0]            blue,
	input  logic [14:0]           packed_color,
	output logic                  empty,
	input  logic                  pop,
	output logic                  data_bit,
	output logic                  clock_pulse,
	output logic                  busy_res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	back_status_t status;
	item_t        item;
	logic         item_empty;
	logic         item_pop;
	logic         res_full;
	logic         res_push;
	result_t      res;
	result_t      res_head;

	assign cfg_ready = 1'b1;

	slsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.packed_color(packed_color),
		.status      (status),
		.item_pop    (item_pop),
		.item_empty  (item_empty),
		.item        (item)
	);

	slsf_back #(
		.LED_COUNT(LED_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_empty(item_empty),
		.item      (item),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status)
	);

	slsf_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_head),
		.empty  (empty)
	);

	assign data_bit    = res_head.data_bit;
	assign clock_pulse = res_head.clock_pulse;
	assign busy_res    = res_head.busy;

endmodule

// ===== hw/rtl/slsf_fifo.sv =====
// ----------------------------------------------------------------------------
// slsf_fifo
// Small register queue with show-ahead read.
// ----------------------------------------------------------------------------
module slsf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/slsf_front.sv =====
// ----------------------------------------------------------------------------
// slsf_front
// Accepts input items, classifies the opcode and queues decoded items.
// ----------------------------------------------------------------------------
module slsf_front
	import slsf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [2:0]   opcode,
	input  logic [5:0]   pixel_index,
	input  logic [4:0]   red,
	input  logic [4:0]   green,
	input  logic [4:0]   blue,
	input  logic [14:0]  packed_color,
	input  back_status_t status,
	input  logic         item_pop,
	output logic         item_empty,
	output item_t        item
);

	item_t item_d;
	logic  q_full;

	always_comb begin
		item_d          = '0;
		item_d.index    = pixel_index;
		item_d.color    = packed_color;
		case (opcode)
			OP_TICK: begin
				item_d.is_tick = 1'b1;
			end
			OP_RGB: begin
				item_d.is_write = 1'b1;
				item_d.color    = {red, green, blue};
			end
			OP_PACKED: begin
				item_d.is_write = 1'b1;
			end
			OP_START: begin
				item_d.is_start = 1'b1;
			end
			OP_ANIM: begin
				item_d.is_anim = 1'b1;
			end
			default: begin
				item_d.is_tick = 1'b0;
			end
		endcase
	end

	assign full = q_full || status.init;

	slsf_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && !full),
		.wr_data(item_d),
		.full   (q_full),
		.rd_en  (item_pop),
		.rd_data(item),
		.empty  (item_empty)
	);

endmodule

// ===== hw/rtl/slsf_back.sv =====
// ----------------------------------------------------------------------------
// slsf_back
// Executes queued items: pixel store, frame sequencer and animation steps.
// ----------------------------------------------------------------------------
module slsf_back
	import slsf_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_empty,
	input  item_t                 item,
	output logic                  item_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output result_t               res,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output back_status_t          status
);

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [AW-1:0] LAST = AW'(LED_COUNT - 1);

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;
	localparam logic [1:0] PH_IDLE   = 2'd3;

	logic [15:0]   store [LED_COUNT];
	logic [15:0]   rd_data_s1;

	logic [1:0]    phase_q, phase_d;
	logic [5:0]    bit_cnt_q, bit_cnt_d;
	logic [AW-1:0] led_pos_q, led_pos_d;
	logic          level_q, level_d;
	logic [15:0]   word_q, word_d;
	logic          word_vld_q, word_vld_d;
	logic          rd_pend_q;
	logic [1:0]    anim_mode_q, anim_mode_d;
	logic [14:0]   anim_color_q, anim_color_d;
	logic [AW-1:0] anim_pos_q, anim_pos_d;
	logic          anim_first_q, anim_first_d;
	logic          sweep_q, sweep_d;
	logic          init_q, init_d;
	logic [AW-1:0] sweep_addr_q, sweep_addr_d;
	logic          spec_en_q, spec_en_d;
	logic [AW-1:0] spec_addr_q, spec_addr_d;
	logic [14:0]   spec_color_q, spec_color_d;

	logic          need_fetch;
	logic          take;
	logic [15:0]   word_eff;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata;
	logic [10:0]   idx_ext;
	logic          idx_ok;
	logic          lvl;
	logic          busy_before;

	assign need_fetch = (phase_q == PH_DATA) && !word_vld_q && !rd_pend_q;
	assign take       = !item_empty && !sweep_q && !need_fetch && !res_full;
	assign item_pop   = take;
	assign res_push   = take;
	assign word_eff   = rd_pend_q ? rd_data_s1 : word_q;
	assign idx_ext    = {5'd0, item.index};
	assign idx_ok     = (idx_ext < 11'(LED_COUNT));
	assign status.init = init_q;

	always_comb begin
		phase_d      = phase_q;
		bit_cnt_d    = bit_cnt_q;
		led_pos_d    = led_pos_q;
		level_d      = level_q;
		word_d       = rd_pend_q ? rd_data_s1 : word_q;
		word_vld_d   = word_vld_q || rd_pend_q;
		anim_mode_d  = anim_mode_q;
		anim_color_d = anim_color_q;
		anim_pos_d   = anim_pos_q;
		anim_first_d = anim_first_q;
		sweep_d      = sweep_q;
		init_d       = init_q;
		sweep_addr_d = sweep_addr_q;
		spec_en_d    = spec_en_q;
		spec_addr_d  = spec_addr_q;
		spec_color_d = spec_color_q;
		mem_we       = 1'b0;
		mem_addr     = sweep_addr_q;
		mem_wdata    = PIX_MARK;
		lvl          = level_q;
		busy_before  = (phase_q != PH_IDLE);
		res          = '0;

		// clearing pass
		if (sweep_q) begin
			mem_we = 1'b1;
			if (spec_en_q && (sweep_addr_q == spec_addr_q)) begin
				mem_wdata = {1'b1, spec_color_q};
			end
			if (sweep_addr_q == LAST) begin
				sweep_d = 1'b0;
				init_d  = 1'b0;
			end else begin
				sweep_addr_d = sweep_addr_q + 1'b1;
			end
		end

		if (take) begin
			if (item.is_tick) begin
				case (phase_q)
					PH_START: begin
						bit_cnt_d = '0;
						led_pos_d = '0;
						phase_d   = PH_HEADER;
					end
					PH_HEADER: begin
						lvl     = 1'b0;
						level_d = 1'b0;
						if (bit_cnt_q == 6'd31) begin
							phase_d    = PH_DATA;
							bit_cnt_d  = '0;
							led_pos_d  = '0;
							word_vld_d = 1'b0;
						end else begin
							bit_cnt_d = bit_cnt_q + 1'b1;
						end
					end
					PH_DATA: begin
						lvl       = word_eff[4'd15 - bit_cnt_q[3:0]];
						level_d   = lvl;
						bit_cnt_d = bit_cnt_q + 1'b1;
						if (bit_cnt_q[3:0] == 4'd15) begin
							bit_cnt_d  = '0;
							word_vld_d = 1'b0;
							if (led_pos_q == LAST) begin
								level_d = 1'b0;
								phase_d = PH_IDLE;
							end else begin
								led_pos_d = led_pos_q + 1'b1;
							end
						end
					end
					default: begin
						lvl = level_q;
					end
				endcase
			end

			if (item.is_write && idx_ok) begin
				mem_we    = 1'b1;
				mem_addr  = idx_ext[AW-1:0];
				mem_wdata = {1'b1, item.color};
				if (idx_ext[AW-1:0] == led_pos_q) begin
					word_d = {1'b1, item.color};
				end
			end

			if (item.is_start) begin
				bit_cnt_d  = '0;
				led_pos_d  = '0;
				phase_d    = PH_START;
				word_vld_d = 1'b0;
			end

			if (item.is_anim && (anim_mode_q == ANIM_PIXEL)) begin
				sweep_d      = 1'b1;
				sweep_addr_d = '0;
				spec_en_d    = 1'b1;
				spec_addr_d  = anim_pos_q;
				spec_color_d = anim_color_q;
				anim_pos_d   = (anim_pos_q == LAST) ? '0 : anim_pos_q + 1'b1;
				bit_cnt_d    = '0;
				led_pos_d    = '0;
				phase_d      = PH_START;
				word_vld_d   = 1'b0;
			end

			if (item.is_anim && (anim_mode_q == ANIM_LINE)) begin
				if (anim_pos_q == '0) begin
					sweep_d      = 1'b1;
					sweep_addr_d = '0;
					spec_en_d    = !anim_first_q;
					spec_addr_d  = '0;
					spec_color_d = anim_color_q;
				end else begin
					mem_we    = 1'b1;
					mem_addr  = anim_pos_q;
					mem_wdata = {1'b1, anim_color_q};
				end
				if (anim_first_q) begin
					anim_first_d = 1'b0;
				end else if (anim_pos_q == LAST) begin
					anim_pos_d   = '0;
					anim_first_d = 1'b1;
				end else begin
					anim_pos_d = anim_pos_q + 1'b1;
				end
				bit_cnt_d  = '0;
				led_pos_d  = '0;
				phase_d    = PH_START;
				word_vld_d = 1'b0;
			end

			res.data_bit    = lvl;
			res.clock_pulse = item.is_tick;
			res.busy        = busy_before || (phase_d != PH_IDLE);
		end

		if (cfg_valid) begin
			case (cfg_index)
				CFG_ANIM_MODE: begin
					anim_mode_d  = cfg_data[1:0];
					anim_pos_d   = '0;
					anim_first_d = 1'b1;
				end
				CFG_ANIM_COLOR: begin
					anim_color_d = cfg_data[14:0];
				end
				default: begin
					anim_color_d = anim_color_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			bit_cnt_q    <= '0;
			led_pos_q    <= '0;
			level_q      <= 1'b0;
			word_vld_q   <= 1'b0;
			rd_pend_q    <= 1'b0;
			anim_mode_q  <= '0;
			anim_color_q <= '0;
			anim_pos_q   <= '0;
			anim_first_q <= 1'b1;
			sweep_q      <= 1'b1;
			init_q       <= 1'b1;
			sweep_addr_q <= '0;
			spec_en_q    <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			bit_cnt_q    <= bit_cnt_d;
			led_pos_q    <= led_pos_d;
			level_q      <= level_d;
			word_vld_q   <= word_vld_d;
			rd_pend_q    <= need_fetch;
			anim_mode_q  <= anim_mode_d;
			anim_color_q <= anim_color_d;
			anim_pos_q   <= anim_pos_d;
			anim_first_q <= anim_first_d;
			sweep_q      <= sweep_d;
			init_q       <= init_d;
			sweep_addr_q <= sweep_addr_d;
			spec_en_q    <= spec_en_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q       <= word_d;
		spec_addr_q  <= spec_addr_d;
		spec_color_q <= spec_color_d;
	end

	// pixel store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_addr] <= mem_wdata;
		end
		rd_data_s1 <= store[led_pos_q];
	end

endmodule

// ===== hw/rtl/slsf_checker.sv =====
// ----------------------------------------------------------------------------
// slsf_checker
// Port-level checks of the LED strip frame serializer.
// ----------------------------------------------------------------------------
module slsf_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic data_bit,
	input logic clock_pulse,
	input logic busy_res,
	input logic cfg_valid,
	input logic cfg_ready
);

	// clearing pass blocks input right after reset
	a_init_full: assert property (@(posedge clk)
		$rose(arst_n) |-> full && empty)
		else $error("input open or result present right after reset");

	// idle line is always low
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !busy_res |-> !data_bit)
		else $error("data high outside a frame");

	// waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(data_bit) && $stable(clock_pulse)
			&& $stable(busy_res))
		else $error("waiting result changed");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind led_strip_frame_serializer_core slsf_checker u_slsf_checker (.*);

// ===== tb/tb_led_strip_frame_serializer_core.sv =====
// ----------------------------------------------------------------------------
// tb_led_strip_frame_serializer_core
// Self-checking bench for the RGB555 LED strip frame serializer.
// ----------------------------------------------------------------------------
// Commands go in through the push/full queue, and every accepted command is
// run through a cycle-free model of the pixel store, the frame sequencer and
// the animation logic. The model gives the expected data level, clock pulse
// and busy flag. Results popped from the block are compared with these, in
// order. The run covers directed corner commands, random mixes under several
// animation settings, and frame passes that run through the header well into
// the pixel data. Both sides idle at random, and the receiver stalls once for
// a long stretch.
// ----------------------------------------------------------------------------
module tb_led_strip_frame_serializer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import slsf_pkg::*;

	localparam int LEDS        = LED_COUNT_DEF;
	localparam int PASS_TICKS  = 1 + 32 + 16 * 5;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AFTER  = 150;

	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
	localparam logic [1:0] ANIM_NONE       = 2'd0;
	localparam logic [1:0] ANIM_UNUSED     = 2'd3;

	typedef enum bit [1:0] {
		SEND_START,
		SEND_HEADER,
		SEND_DATA,
		SEND_IDLE
	} send_phase_e;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  idx;
		logic [4:0]  r;
		logic [4:0]  g;
		logic [4:0]  b;
		logic [14:0] pc;
	} strip_cmd_t;

	class strip_checker;
		send_phase_e phase;
		bit [5:0]    bit_cnt;
		bit [6:0]    led_pos;
		bit          level;
		bit [15:0]   store [LEDS];
		bit [6:0]    anim_pos;
		bit          anim_first;
		bit [1:0]    mode;
		bit [14:0]   color;
		result_t     pending_pulses[$];
		int          errors;
		int          popped;
		int          cmds;
		int          ticks;
		int          writes;
		int          anims;
		int          reg_writes;

		function new();
			phase      = SEND_START;
			bit_cnt    = '0;
			led_pos    = '0;
			level      = 1'b0;
			anim_pos   = '0;
			anim_first = 1'b1;
			mode       = ANIM_NONE;
			color      = '0;
			clear_store();
		endfunction

		function void clear_store();
			foreach (store[i]) store[i] = PIX_MARK;
		endfunction

		function void paint(int idx, bit [14:0] col);
			if (idx < LEDS) store[idx] = {1'b1, col};
		endfunction

		function void restart_frame();
			bit_cnt = '0;
			led_pos = '0;
			phase   = SEND_START;
		endfunction

		function bit strip_tick();
			bit        lvl;
			bit [15:0] word;
			lvl = level;
			case (phase)
				SEND_START: begin
					bit_cnt = '0;
					led_pos = '0;
					phase   = SEND_HEADER;
				end
				SEND_HEADER: begin
					lvl   = 1'b0;
					level = 1'b0;
					bit_cnt++;
					if (bit_cnt >= 32) begin
						phase   = SEND_DATA;
						led_pos = '0;
						bit_cnt = '0;
					end
				end
				SEND_DATA: begin
					word  = (led_pos < LEDS) ? store[led_pos] : 16'h0;
					lvl   = word[4'd15 - bit_cnt[3:0]];
					level = lvl;
					bit_cnt++;
					if (bit_cnt >= 16) begin
						led_pos++;
						bit_cnt = '0;
						if (led_pos >= LEDS) begin
							level = 1'b0;
							phase = SEND_IDLE;
						end
					end
				end
				default: ;
			endcase
			return lvl;
		endfunction

		function void step_animation();
			if (anim_pos >= LEDS) anim_pos = '0;
			if (mode == ANIM_PIXEL) begin
				clear_store();
				paint(anim_pos, color);
				anim_pos++;
				if (anim_pos >= LEDS) anim_pos = '0;
				restart_frame();
			end else if (mode == ANIM_LINE) begin
				if (anim_pos == 0) clear_store();
				if (!anim_first) begin
					paint(anim_pos, color);
					anim_pos++;
				end else begin
					anim_first = 1'b0;
				end
				if (anim_pos >= LEDS) begin
					anim_pos   = '0;
					anim_first = 1'b1;
				end
				restart_frame();
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			reg_writes++;
			if (idx == CFG_ANIM_MODE) begin
				mode       = data[1:0];
				anim_pos   = '0;
				anim_first = 1'b1;
			end else begin
				color = data;
			end
		endfunction

		function void take_cmd(strip_cmd_t c);
			bit      was_busy;
			result_t want;
			was_busy = (phase != SEND_IDLE);
			want.clock_pulse = 1'b0;
			cmds++;
			case (c.op)
				OP_TICK: begin
					want.data_bit    = strip_tick();
					want.clock_pulse = 1'b1;
					ticks++;
				end
				OP_RGB: begin
					paint(c.idx, {c.r, c.g, c.b});
					want.data_bit = level;
					writes++;
				end
				OP_PACKED: begin
					paint(c.idx, c.pc);
					want.data_bit = level;
					writes++;
				end
				OP_START: begin
					restart_frame();
					want.data_bit = level;
				end
				OP_ANIM: begin
					step_animation();
					want.data_bit = level;
					anims++;
				end
				default: want.data_bit = level;
			endcase
			want.busy = was_busy || (phase != SEND_IDLE);
			pending_pulses.push_back(want);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at result %0d: %s", popped, msg);
			errors++;
		endtask

		task check_output(result_t got);
			result_t want;
			popped++;
			if (pending_pulses.size() == 0) begin
				report_mismatch("result with no command outstanding");
			end else begin
				want = pending_pulses.pop_front();
				if (got.data_bit !== want.data_bit)
					report_mismatch($sformatf("data_bit %b, expected %b",
						got.data_bit, want.data_bit));
				if (got.clock_pulse !== want.clock_pulse)
					report_mismatch($sformatf("clock_pulse %b, expected %b",
						got.clock_pulse, want.clock_pulse));
				if (got.busy !== want.busy)
					report_mismatch($sformatf("busy_res %b, expected %b",
						got.busy, want.busy));
			end
		endtask

		function int pending();
			return pending_pulses.size();
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  push         = 1'b0;
	logic                  full;
	logic [2:0]            opcode       = '0;
	logic [5:0]            pixel_index  = '0;
	logic [4:0]            red          = '0;
	logic [4:0]            green        = '0;
	logic [4:0]            blue         = '0;
	logic [14:0]           packed_color = '0;
	logic                  empty;
	logic                  pop          = 1'b0;
	logic                  data_bit;
	logic                  clock_pulse;
	logic                  busy_res;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	strip_checker sb;
	bit           no_idle = 1'b0;
	bit           held_once = 1'b0;
	int           quiet_cycles = 0;

	led_strip_frame_serializer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.packed_color(packed_color),
		.empty       (empty),
		.pop         (pop),
		.data_bit    (data_bit),
		.clock_pulse (clock_pulse),
		.busy_res    (busy_res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 65) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic strip_cmd_t mk_cmd(logic [2:0] op);
		strip_cmd_t c;
		c.op  = op;
		c.idx = 6'($urandom);
		c.r   = 5'($urandom);
		c.g   = 5'($urandom);
		c.b   = 5'($urandom);
		c.pc  = 15'($urandom);
		return c;
	endfunction

	function automatic strip_cmd_t mk_pixel(logic [2:0] op, logic [5:0] idx,
			logic [4:0] r, logic [4:0] g, logic [4:0] b, logic [14:0] pc);
		strip_cmd_t c;
		c = '{op: op, idx: idx, r: r, g: g, b: b, pc: pc};
		return c;
	endfunction

	function automatic logic [2:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return OP_TICK;
		if (roll < 67) return OP_RGB;
		if (roll < 79) return OP_PACKED;
		if (roll < 85) return OP_START;
		if (roll < 95) return OP_ANIM;
		return 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
	endfunction

	task automatic send_cmd(strip_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		opcode       <= c.op;
		pixel_index  <= c.idx;
		red          <= c.r;
		green        <= c.g;
		blue         <= c.b;
		packed_color <= c.pc;
		do @(posedge clk); while (full);
		sb.take_cmd(c);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(logic [1:0] m, logic [14:0] col);
		logic [CFG_DATA_W-1:0] mode_word;
		settle();
		mode_word = {13'($urandom), m};
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ANIM_MODE;
		cfg_data  <= mode_word;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_ANIM_MODE, mode_word);
		cfg_index <= CFG_ANIM_COLOR;
		cfg_data  <= col;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_ANIM_COLOR, col);
		cfg_valid <= 1'b0;
	endtask

	task automatic frame_pass(logic [2:0] kick);
		strip_cmd_t c;
		send_cmd(mk_cmd(kick));
		repeat (PASS_TICKS) begin
			if ($urandom_range(0, 99) < 8) begin
				c     = mk_cmd($urandom_range(0, 1) ? OP_RGB : OP_PACKED);
				c.idx = 6'($urandom_range(0, 5));
				send_cmd(c);
			end else begin
				send_cmd(mk_cmd(OP_TICK));
			end
		end
	endtask

	task automatic take_results();
		int      gap;
		result_t got;
		forever begin
			if (!held_once && sb.popped >= HOLD_AFTER) begin
				held_once = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.data_bit    = data_bit;
			got.clock_pulse = clock_pulse;
			got.busy        = busy_res;
			sb.check_output(got);
		end
	endtask

	logic [1:0]  phase_modes  [6] = '{ANIM_NONE, ANIM_PIXEL, ANIM_LINE,
		ANIM_PIXEL, ANIM_LINE, ANIM_UNUSED};
	logic [14:0] phase_colors [6] = '{15'h7FFF, 15'h0000, 15'h1234,
		15'h7FFF, 15'h4A5B, 15'h0000};

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			take_results();
		join_none

		// reset store frame starts on the first ticks; corner writes and ops
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_pixel(OP_RGB, 6'd0, 5'd31, 5'd0, 5'd31, 15'h0000));
		send_cmd(mk_pixel(OP_RGB, 6'd63, 5'd0, 5'd31, 5'd0, 15'h7FFF));
		send_cmd(mk_pixel(OP_RGB, 6'd21, 5'd0, 5'd0, 5'd0, 15'h0000));
		send_cmd(mk_pixel(OP_PACKED, 6'd63, 5'd31, 5'd31, 5'd31, 15'h7FFF));
		send_cmd(mk_pixel(OP_PACKED, 6'd0, 5'd31, 5'd31, 5'd31, 15'h0000));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_START));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_ANIM));
		send_cmd(mk_cmd(OP_UNUSED_FIRST));
		send_cmd(mk_cmd(OP_UNUSED_LAST));

		configure(ANIM_PIXEL, 15'h7FFF);
		send_cmd(mk_cmd(OP_ANIM));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_ANIM));

		configure(ANIM_LINE, 15'h0000);
		send_cmd(mk_cmd(OP_ANIM));
		send_cmd(mk_cmd(OP_ANIM));
		send_cmd(mk_cmd(OP_TICK));
		send_cmd(mk_cmd(OP_ANIM));

		configure(ANIM_UNUSED, 15'h2AAA);
		send_cmd(mk_cmd(OP_ANIM));
		send_cmd(mk_cmd(OP_TICK));

		// random mixes under several animation settings
		for (int p = 0; p < 6; p++) begin
			configure(phase_modes[p], phase_colors[p]);
			no_idle = (p == 2);
			repeat (55) send_cmd(mk_cmd(pick_op()));
		end

		// frames through the header and several pixels, with writes near the bit position
		configure(ANIM_NONE, 15'h5555);
		no_idle = 1'b1;
		frame_pass(OP_START);
		no_idle = 1'b0;
		configure(ANIM_LINE, 15'h7FFF);
		repeat (3) send_cmd(mk_cmd(OP_ANIM));
		frame_pass(OP_ANIM);

		settle();
		repeat (20) @(posedge clk);
		$display("covered %0d commands: %0d ticks, %0d pixel writes, %0d animation steps",
			sb.cmds, sb.ticks, sb.writes, sb.anims);
		$display("%0d register writes, %0d results checked", sb.reg_writes, sb.popped);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
